// ===== design/sdq_pkg.sv =====
package sdq_pkg;

  // Default number of store entries.
  localparam int unsigned SdqDepth = 64;

  // Fixed field widths of the request and response payloads.
  localparam int unsigned ValueW = 32;
  localparam int unsigned ActionW = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned EntryCountW = 7;

  // Action codes carried by a request.
  typedef enum logic [ActionW-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_SORT       = 3'd4
  } action_e;

  // Status codes returned with a response.
  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Command kinds after decoding in the front part.
  typedef enum logic [2:0] {
    CMD_PUSH_FRONT,
    CMD_PUSH_BACK,
    CMD_POP_FRONT,
    CMD_POP_BACK,
    CMD_SORT,
    CMD_NOP
  } cmd_kind_e;

  // States of the back-part engine.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_POP_DATA,
    BK_SORT_START,
    BK_SORT_FIRST,
    BK_SORT_STEP,
    BK_SORT_TAIL,
    BK_SORT_DONE
  } back_state_e;

  // Request payload.
  typedef struct packed {
    logic [ActionW-1:0]       action;
    logic signed [ValueW-1:0] push_value;
  } sdq_req_t;

  // Response payload.
  typedef struct packed {
    logic signed [ValueW-1:0] popped_value;
    logic [StatusW-1:0]       status;
    logic [EntryCountW-1:0]   entry_count;
  } sdq_rsp_t;

  // Decoded command handed from the front part to the back part.
  typedef struct packed {
    cmd_kind_e                kind;
    logic signed [ValueW-1:0] value;
  } sdq_cmd_t;

endpackage

// ===== design/sdq_front.sv =====
module sdq_front
  import sdq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  sdq_req_t in_req_i,
  output logic     cmd_valid_o,
  output sdq_cmd_t cmd_o,
  input  logic     cmd_take_i
);

  sdq_cmd_t   slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  sdq_cmd_t   dec_cmd;
  logic       push, pop;

  // Classify the request into a command kind.
  always_comb begin
    dec_cmd.value = in_req_i.push_value;
    unique case (action_e'(in_req_i.action))
      ACT_PUSH_FRONT: dec_cmd.kind = CMD_PUSH_FRONT;
      ACT_PUSH_BACK:  dec_cmd.kind = CMD_PUSH_BACK;
      ACT_POP_FRONT:  dec_cmd.kind = CMD_POP_FRONT;
      ACT_POP_BACK:   dec_cmd.kind = CMD_POP_BACK;
      ACT_SORT:       dec_cmd.kind = CMD_SORT;
      default:        dec_cmd.kind = CMD_NOP;
    endcase
  end

  // Two-entry command queue; the input stalls only when it is full.
  assign in_stall_o  = (fill_q == 2'd2);
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = cmd_take_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 2'd1;
    end else if (pop && !push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Queue slots carry payload only.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= dec_cmd;
    end
  end

endmodule

// ===== design/sdq_back.sv =====
module sdq_back
  import sdq_pkg::*;
#(
  parameter int unsigned DEPTH = SdqDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cmd_valid_i,
  input  sdq_cmd_t cmd_i,
  output logic     cmd_take_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output sdq_rsp_t out_rsp_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW:0]   DepthWide = (PtrW + 1)'(DEPTH);
  localparam logic [CntW-1:0] DepthCnt  = CntW'(DEPTH);
  localparam logic [PtrW-1:0] LastPos   = PtrW'(DEPTH - 1);

  // Ring position of an offset from a base, both below DEPTH.
  function automatic logic [PtrW-1:0] ring_add(input logic [PtrW-1:0] pos,
                                               input logic [PtrW-1:0] off);
    logic [PtrW:0] sum;
    sum = {1'b0, pos} + {1'b0, off};
    if (sum >= DepthWide) begin
      sum = sum - DepthWide;
    end
    return sum[PtrW-1:0];
  endfunction

  back_state_e state_q, state_d;
  logic [PtrW-1:0] front_q, front_d;
  logic [CntW-1:0] count_q, count_d;
  logic [PtrW-1:0] idx_q, idx_d;
  logic signed [ValueW-1:0] carry_q, carry_d;
  logic swapped_q, swapped_d;
  logic signed [ValueW-1:0] mem_q [DEPTH];
  logic signed [ValueW-1:0] rdata_q;
  logic out_valid_q, out_valid_d;
  sdq_rsp_t rsp_q, rsp_d;

  logic out_free, rsp_load;
  logic mem_we, rd_en;
  logic [PtrW-1:0] waddr, raddr;
  logic signed [ValueW-1:0] wdata;
  logic is_empty, is_full, few_entries, greater, last_step;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign is_empty    = (count_q == '0);
  assign is_full     = (count_q == DepthCnt);
  assign few_entries = (count_q <= CntW'(1));
  assign greater     = carry_q > rdata_q;
  assign last_step   = (idx_q == PtrW'(count_q - CntW'(1)));

  // Next state of the engine.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && out_free) begin
          if ((cmd_i.kind == CMD_POP_FRONT || cmd_i.kind == CMD_POP_BACK) && !is_empty) begin
            state_d = BK_POP_DATA;
          end else if (cmd_i.kind == CMD_SORT && !few_entries) begin
            state_d = BK_SORT_START;
          end
        end
      end
      BK_POP_DATA: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      BK_SORT_START: state_d = BK_SORT_FIRST;
      BK_SORT_FIRST: state_d = BK_SORT_STEP;
      BK_SORT_STEP: begin
        if (last_step) begin
          state_d = BK_SORT_TAIL;
        end
      end
      BK_SORT_TAIL: state_d = swapped_q ? BK_SORT_START : BK_SORT_DONE;
      BK_SORT_DONE: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Datapath control, store accesses and response formation.
  always_comb begin
    cmd_take_o = 1'b0;
    front_d    = front_q;
    count_d    = count_q;
    idx_d      = idx_q;
    carry_d    = carry_q;
    swapped_d  = swapped_q;
    mem_we     = 1'b0;
    waddr      = front_q;
    wdata      = cmd_i.value;
    rd_en      = 1'b0;
    raddr      = front_q;
    rsp_load   = 1'b0;
    rsp_d.popped_value = '0;
    rsp_d.status       = ST_OK;
    rsp_d.entry_count  = EntryCountW'(count_q);

    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_take_o = 1'b1;
          unique case (cmd_i.kind)
            CMD_PUSH_FRONT: begin
              rsp_load = 1'b1;
              if (is_full) begin
                rsp_d.status = ST_FULL;
              end else begin
                front_d = (front_q == '0) ? LastPos : front_q - PtrW'(1);
                mem_we  = 1'b1;
                waddr   = front_d;
                count_d = count_q + CntW'(1);
                rsp_d.entry_count = EntryCountW'(count_d);
              end
            end
            CMD_PUSH_BACK: begin
              rsp_load = 1'b1;
              if (is_full) begin
                rsp_d.status = ST_FULL;
              end else begin
                mem_we  = 1'b1;
                waddr   = ring_add(front_q, PtrW'(count_q));
                count_d = count_q + CntW'(1);
                rsp_d.entry_count = EntryCountW'(count_d);
              end
            end
            CMD_POP_FRONT: begin
              if (is_empty) begin
                rsp_load     = 1'b1;
                rsp_d.status = ST_EMPTY;
              end else begin
                rd_en   = 1'b1;
                raddr   = front_q;
                front_d = ring_add(front_q, PtrW'(1));
                count_d = count_q - CntW'(1);
              end
            end
            CMD_POP_BACK: begin
              if (is_empty) begin
                rsp_load     = 1'b1;
                rsp_d.status = ST_EMPTY;
              end else begin
                rd_en   = 1'b1;
                raddr   = ring_add(front_q, PtrW'(count_q - CntW'(1)));
                count_d = count_q - CntW'(1);
              end
            end
            CMD_SORT: begin
              // A queue of zero or one entry is already in order.
              rsp_load = few_entries;
            end
            default: begin
              rsp_load = 1'b1;
            end
          endcase
        end
      end
      BK_POP_DATA: begin
        if (out_free) begin
          rsp_load = 1'b1;
          rsp_d.popped_value = rdata_q;
        end
      end
      BK_SORT_START: begin
        // Open a pass by fetching the front entry.
        rd_en     = 1'b1;
        raddr     = front_q;
        swapped_d = 1'b0;
      end
      BK_SORT_FIRST: begin
        carry_d = rdata_q;
        rd_en   = 1'b1;
        raddr   = ring_add(front_q, PtrW'(1));
        idx_d   = PtrW'(1);
      end
      BK_SORT_STEP: begin
        // The larger value travels on; the smaller one settles one place back.
        mem_we    = 1'b1;
        waddr     = ring_add(front_q, idx_q - PtrW'(1));
        wdata     = greater ? rdata_q : carry_q;
        carry_d   = greater ? carry_q : rdata_q;
        swapped_d = swapped_q | greater;
        if (!last_step) begin
          rd_en = 1'b1;
          raddr = ring_add(front_q, idx_q + PtrW'(1));
          idx_d = idx_q + PtrW'(1);
        end
      end
      BK_SORT_TAIL: begin
        mem_we = 1'b1;
        waddr  = ring_add(front_q, idx_q);
        wdata  = carry_q;
      end
      BK_SORT_DONE: begin
        rsp_load = out_free;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_d = rsp_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Sort work registers and the response register carry payload only.
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    carry_q   <= carry_d;
    swapped_q <= swapped_d;
    if (rsp_load) begin
      rsp_q <= rsp_d;
    end
  end

  // Entry store with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

// ===== design/sortable_double_ended_queue.sv =====
// Channel   Direction  Handshake               Payload
// request   in         in_valid_i, in_stall_o    in_req_i (sdq_req_t)
// response  out        out_valid_o, out_stall_i  out_rsp_o (sdq_rsp_t)
//
// Requests are registered in a two-entry command queue before reaching the engine.
// Pushes, refused pushes, empty pops, unknown actions and sorts of fewer than two
// entries are answered from the idle state; a pop adds a data state for the store read.
// A sort of n > 1 entries repeats adjacent-swap passes (start, first, step, tail) until
// one swaps nothing. Reset clears the engine state, pointers, count and handshakes only.
// Outside sort passes a stalled response holds the engine; a full queue stalls requests.
module sortable_double_ended_queue
  import sdq_pkg::*;
#(
  parameter int unsigned DEPTH = SdqDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  sdq_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output sdq_rsp_t out_rsp_o
);

  logic     cmd_valid;
  logic     cmd_take;
  sdq_cmd_t cmd;

  // Front part: decode and queue the requests.
  sdq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  // Back part: store, pointers, sort engine and response register.
  sdq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  // A full command queue always offers a command to the engine.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> cmd_valid)
    else $error("request stalled while the command queue is empty");

  // A refused push only happens with the store full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.status == ST_FULL)
      |-> (out_rsp_o.entry_count == EntryCountW'(DEPTH)))
    else $error("full status with a count below the depth");

  // A pop on an empty queue reports no entries and no value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.status == ST_EMPTY)
      |-> (out_rsp_o.popped_value == '0 && out_rsp_o.entry_count == '0))
    else $error("empty status with entries or a value");

  // The engine takes no command while a response is stuck.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !cmd_take)
    else $error("command taken while the response is stalled");

endmodule
